>>> rtl/crbb_pkg.sv
// ----------------------------------------------------------------------------
// crbb_pkg
// Shared widths, codes and types for the circular receive byte buffer.
// ----------------------------------------------------------------------------
package crbb_pkg;

   localparam int MAX_RECEIVE   = 4095;
   localparam int DEPTH         = MAX_RECEIVE + 1;
   localparam int PTR_W         = $clog2(DEPTH);
   localparam int DATA_W        = 8;
   localparam int ACTION_W      = 3;
   localparam int BLOCK_MAX_DEF = 64;

   typedef enum logic [ACTION_W-1:0] {
      ACT_STORE   = 3'd0,
      ACT_COMMIT  = 3'd1,
      ACT_CLEAR   = 3'd2,
      ACT_READ    = 3'd3,
      ACT_PEEK    = 3'd4,
      ACT_BLOCK   = 3'd5,
      ACT_PUTBACK = 3'd6
   } action_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

endpackage

>>> rtl/crbb_req_if.sv
// ----------------------------------------------------------------------------
// crbb_req_if
// Request channel: one buffer action per transfer.
// ----------------------------------------------------------------------------
interface crbb_req_if;
   import crbb_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [DATA_W-1:0]   data_in;
   logic                has_byte;
   logic [PTR_W-1:0]    offset;
   logic [PTR_W-1:0]    count;

   modport source (output valid, action, data_in, has_byte, offset, count, input ready);
   modport sink   (input valid, action, data_in, has_byte, offset, count, output ready);

endinterface

>>> rtl/crbb_rsp_if.sv
// ----------------------------------------------------------------------------
// crbb_rsp_if
// Response channel: one byte or status word per transfer.
// ----------------------------------------------------------------------------
interface crbb_rsp_if;
   import crbb_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_out;
   logic              data_valid;
   logic              op_ok;
   logic              last;
   logic [PTR_W-1:0]  available;
   logic [PTR_W-1:0]  free_start;
   logic [PTR_W-1:0]  free_length;

   modport source (output valid, data_out, data_valid, op_ok, last, available,
                   free_start, free_length, input ready);
   modport sink   (input valid, data_out, data_valid, op_ok, last, available,
                   free_start, free_length, output ready);

endinterface

>>> rtl/circular_receive_byte_buffer.sv
// ----------------------------------------------------------------------------
// circular_receive_byte_buffer
// Byte ring with read position, write end and putback floor, held in one
// synchronous memory with a registered read port.
// Store, commit, clear, putback, empty reads: result in the next cycle. Read,
// peek: byte passes the memory read register, then the response register.
// Block read: first byte likewise, then one byte per cycle. One request per
// cycle for non-reading actions; both rates need a free response channel. A
// read holds the request channel until its final byte is registered. Reset
// clears positions and floor; ring contents are undefined until written.
// ----------------------------------------------------------------------------
module circular_receive_byte_buffer #(
   parameter int BLOCK_MAX = crbb_pkg::BLOCK_MAX_DEF
) (
   input logic      clock,
   input logic      reset,
   crbb_req_if.sink   req_chan,
   crbb_rsp_if.source rsp_chan
);
   import crbb_pkg::*;

   localparam int               CNT_W     = $clog2(BLOCK_MAX + 1);
   localparam logic [PTR_W-1:0] BLOCK_LIM = PTR_W'(BLOCK_MAX);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

   logic [DATA_W-1:0] ring_mem [DEPTH];

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [PTR_W-1:0]  we_ff, we_in;
   logic [PTR_W-1:0]  floor_ff, floor_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic              adv_ff, adv_in;
   logic [DATA_W-1:0] rd_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_dv_ff, rsp_dv_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [PTR_W-1:0]  rsp_avail_ff, rsp_avail_in;
   logic [PTR_W-1:0]  rsp_fstart_ff;
   logic [PTR_W-1:0]  rsp_flen_ff, rsp_flen_in;

   logic              out_free;
   logic              accept;
   logic              load;
   action_type        act;
   logic [PTR_W-1:0]  avail_cur;
   logic [PTR_W-1:0]  cnt_sat;
   logic [PTR_W-1:0]  blk_n;
   logic [PTR_W-1:0]  prev_rd;

   logic              mem_we;
   logic [PTR_W-1:0]  mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic              mem_re;
   logic [PTR_W-1:0]  mem_raddr;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign accept         = req_chan.valid && req_chan.ready;
   assign act            = action_type'(req_chan.action);

   assign avail_cur = we_ff - rd_ff;
   assign cnt_sat   = (req_chan.count > BLOCK_LIM) ? BLOCK_LIM : req_chan.count;
   assign blk_n     = (cnt_sat > avail_cur) ? avail_cur : cnt_sat;

   always_comb begin
      state_in    = state_ff;
      rd_in       = rd_ff;
      we_in       = we_ff;
      floor_in    = floor_ff;
      rem_in      = rem_ff;
      adv_in      = adv_ff;
      load        = 1'b0;
      rsp_data_in = '0;
      rsp_dv_in   = 1'b0;
      rsp_ok_in   = 1'b1;
      rsp_last_in = 1'b1;
      mem_we      = 1'b0;
      mem_waddr   = we_ff + req_chan.offset;
      mem_wdata   = req_chan.data_in;
      mem_re      = 1'b0;
      mem_raddr   = rd_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (act)
                  ACT_STORE: begin
                     mem_we = 1'b1;
                     load   = 1'b1;
                  end
                  ACT_COMMIT: begin
                     floor_in = rd_ff;
                     we_in    = we_ff + req_chan.count;
                     load     = 1'b1;
                  end
                  ACT_CLEAR: begin
                     rd_in    = '0;
                     we_in    = '0;
                     floor_in = '0;
                     load     = 1'b1;
                  end
                  ACT_READ, ACT_PEEK: begin
                     if (rd_ff == we_ff) begin
                        load = 1'b1;
                     end else begin
                        mem_re   = 1'b1;
                        rem_in   = CNT_ONE;
                        adv_in   = (act == ACT_READ);
                        state_in = ST_READ;
                     end
                  end
                  ACT_BLOCK: begin
                     if (blk_n == '0) begin
                        load = 1'b1;
                     end else begin
                        mem_re   = 1'b1;
                        rem_in   = blk_n[CNT_W-1:0];
                        adv_in   = 1'b1;
                        state_in = ST_READ;
                     end
                  end
                  ACT_PUTBACK: begin
                     load = 1'b1;
                     if (floor_ff == rd_ff) begin
                        rsp_ok_in = 1'b0;
                     end else begin
                        rd_in     = prev_rd;
                        mem_we    = req_chan.has_byte;
                        mem_waddr = prev_rd;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_data_in = rd_data_ff;
               rsp_dv_in   = 1'b1;
               rsp_last_in = (rem_ff == CNT_ONE);
               if (adv_ff) begin
                  rd_in = rd_ff + PTR_W'(1);
               end
               if (rem_ff == CNT_ONE) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = rd_ff + PTR_W'(1);
                  rem_in    = rem_ff - CNT_ONE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && !rsp_chan.ready);
   end

   // status after the step
   assign prev_rd      = rd_ff - PTR_W'(1);
   assign rsp_avail_in = we_in - rd_in;
   always_comb begin
      logic [PTR_W-1:0] p;
      p = rd_in - PTR_W'(1);
      rsp_flen_in = (we_in <= p) ? (p - we_in) : (PTR_W'(0) - we_in);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= ring_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ff        <= '0;
         we_ff        <= '0;
         floor_ff     <= '0;
         rem_ff       <= '0;
         adv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ff        <= rd_in;
         we_ff        <= we_in;
         floor_ff     <= floor_in;
         rem_ff       <= rem_in;
         adv_ff       <= adv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_dv_ff     <= rsp_dv_in;
         rsp_ok_ff     <= rsp_ok_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_avail_ff  <= rsp_avail_in;
         rsp_fstart_ff <= we_in;
         rsp_flen_ff   <= rsp_flen_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.data_out    = rsp_data_ff;
   assign rsp_chan.data_valid  = rsp_dv_ff;
   assign rsp_chan.op_ok       = rsp_ok_ff;
   assign rsp_chan.last        = rsp_last_ff;
   assign rsp_chan.available   = rsp_avail_ff;
   assign rsp_chan.free_start  = rsp_fstart_ff;
   assign rsp_chan.free_length = rsp_flen_ff;

   a_read_follows : assert property (@(posedge clock) disable iff (reset)
      mem_re |=> state_ff == ST_READ)
      else $error("memory read issued without read state");

   a_rem_nonzero : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> rem_ff != '0)
      else $error("read state with no bytes remaining");

   a_block_open : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> state_ff == ST_READ)
      else $error("non-final transfer pending outside read state");

   a_no_write_in_read : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !mem_we)
      else $error("ring written during a read");

endmodule

>>> sim/tb_circular_receive_byte_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_receive_byte_buffer
// Self-checking bench for the circular receive byte buffer. Actions go in
// over the request channel and are checked against an in-bench byte ring
// model that tracks read position, write end, putback floor and which
// entries hold data. A directed opening covers empty reads, floor hits,
// saturated block reads, wrapping stores and commits, clear and the spare
// action code. The random part is mostly store runs followed by a commit and
// a burst of readers, with raw random actions mixed in. Reads are kept off
// entries that were never written. Both channels stall at random, and twice
// the receiver holds off long enough to back the buffer up into the request
// channel.
// ----------------------------------------------------------------------------
module tb_circular_receive_byte_buffer;
   import crbb_pkg::*;

   localparam int          CLOCK_HALF   = 4;
   localparam int          RESET_CYCLES = 12;
   localparam int          ITEM_TARGET  = 410;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          DRAIN_CYCLES = 20;
   localparam int          CYCLE_LIMIT  = 4_000_000;
   localparam int          BLOCK_LIMIT  = BLOCK_MAX_DEF;
   localparam logic [ACTION_W-1:0] ACT_SPARE = 3'd7;

   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [DATA_W-1:0]   data_in;
      logic                has_byte;
      logic [PTR_W-1:0]    offset;
      logic [PTR_W-1:0]    count;
   } ring_request_type;

   typedef struct {
      logic [DATA_W-1:0] data_out;
      logic              data_valid;
      logic              op_ok;
      logic              last;
      logic [PTR_W-1:0]  available;
      logic [PTR_W-1:0]  free_start;
      logic [PTR_W-1:0]  free_length;
   } ring_status_type;

   class ring_scoreboard_type;
      logic [DATA_W-1:0] ring [DEPTH];
      bit                written [DEPTH];
      logic [PTR_W-1:0]  rd_pos;
      logic [PTR_W-1:0]  wr_end;
      logic [PTR_W-1:0]  floor_pos;
      ring_status_type   pending_results[$];
      int                mismatches;

      function new();
         rd_pos     = '0;
         wr_end     = '0;
         floor_pos  = '0;
         mismatches = 0;
      endfunction

      function logic [PTR_W-1:0] available();
         return wr_end - rd_pos;
      endfunction

      function void push_status(logic [DATA_W-1:0] d, bit dv, bit ok, bit lst);
         ring_status_type  e;
         logic [PTR_W-1:0] prev;
         prev          = rd_pos - 1'b1;
         e.data_out    = d;
         e.data_valid  = dv;
         e.op_ok       = ok;
         e.last        = lst;
         e.available   = wr_end - rd_pos;
         e.free_start  = wr_end;
         e.free_length = (wr_end <= prev) ? prev - wr_end : PTR_W'(DEPTH - int'(wr_end));
         pending_results.push_back(e);
      endfunction

      function void note_action(ring_request_type r);
         logic [PTR_W-1:0] pos;
         int unsigned      n;
         int unsigned      i;
         case (r.action)
            ACT_STORE: begin
               pos          = wr_end + r.offset;
               ring[pos]    = r.data_in;
               written[pos] = 1'b1;
               push_status('0, 1'b0, 1'b1, 1'b1);
            end
            ACT_COMMIT: begin
               floor_pos = rd_pos;
               wr_end    = wr_end + r.count;
               push_status('0, 1'b0, 1'b1, 1'b1);
            end
            ACT_CLEAR: begin
               rd_pos    = '0;
               wr_end    = '0;
               floor_pos = '0;
               push_status('0, 1'b0, 1'b1, 1'b1);
            end
            ACT_READ, ACT_PEEK: begin
               if (rd_pos == wr_end) begin
                  push_status('0, 1'b0, 1'b1, 1'b1);
               end else begin
                  pos = rd_pos;
                  if (r.action == ACT_READ) rd_pos = rd_pos + 1'b1;
                  push_status(ring[pos], 1'b1, 1'b1, 1'b1);
               end
            end
            ACT_BLOCK: begin
               n = 32'(r.count);
               if (n > BLOCK_LIMIT) n = BLOCK_LIMIT;
               if (n > 32'(available())) n = 32'(available());
               if (n == 0) begin
                  push_status('0, 1'b0, 1'b1, 1'b1);
               end else begin
                  for (i = 0; i < n; i++) begin
                     pos    = rd_pos;
                     rd_pos = rd_pos + 1'b1;
                     push_status(ring[pos], 1'b1, 1'b1, i + 1 == n);
                  end
               end
            end
            ACT_PUTBACK: begin
               if (floor_pos == rd_pos) begin
                  push_status('0, 1'b0, 1'b0, 1'b1);
               end else begin
                  rd_pos = rd_pos - 1'b1;
                  if (r.has_byte) begin
                     ring[rd_pos]    = r.data_in;
                     written[rd_pos] = 1'b1;
                  end
                  push_status('0, 1'b0, 1'b1, 1'b1);
               end
            end
            default: push_status('0, 1'b0, 1'b1, 1'b1);
         endcase
      endfunction

      function void compare(string name, logic [PTR_W-1:0] want, logic [PTR_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_transfer(ring_status_type got);
         ring_status_type want;
         if (pending_results.size() == 0) begin
            $error("result transfer with no expectation pending");
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         compare("data_out", want.data_out, got.data_out);
         compare("data_valid", want.data_valid, got.data_valid);
         compare("op_ok", want.op_ok, got.op_ok);
         compare("last", want.last, got.last);
         compare("available", want.available, got.available);
         compare("free_start", want.free_start, got.free_start);
         compare("free_length", want.free_length, got.free_length);
      endfunction
   endclass

   logic clock;
   logic reset;

   crbb_req_if req_chan ();
   crbb_rsp_if rsp_chan ();

   circular_receive_byte_buffer uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ring_scoreboard_type ring_model = new();
   bit                  idle_en       = 1'b1;
   bit                  hold_request  = 1'b0;
   int                  items_sent    = 0;
   int                  cycle_count   = 0;

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      if (!idle_en) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic ring_request_type make_request(logic [ACTION_W-1:0] act,
                                                    logic [DATA_W-1:0] d, logic hb,
                                                    logic [PTR_W-1:0] off,
                                                    logic [PTR_W-1:0] cnt);
      ring_request_type r;
      r.action   = act;
      r.data_in  = d;
      r.has_byte = hb;
      r.offset   = off;
      r.count    = cnt;
      return r;
   endfunction

   function automatic ring_request_type random_request();
      return make_request(ACTION_W'($urandom_range(0, 7)),
                          DATA_W'($urandom_range(0, 255)),
                          ($urandom_range(0, 1) != 0),
                          PTR_W'($urandom_range(0, DEPTH - 1)),
                          PTR_W'($urandom_range(0, DEPTH - 1)));
   endfunction

   // steer readers away from entries that hold no data: fill the entry at
   // the read position instead, or trim the block to the written run
   function automatic ring_request_type keep_to_written(ring_request_type r);
      int unsigned      avail;
      int unsigned      need;
      int unsigned      run;
      logic [PTR_W-1:0] pos;
      avail = 32'(ring_model.available());
      if (avail == 0) return r;
      if (r.action == ACT_READ || r.action == ACT_PEEK) begin
         if (!ring_model.written[ring_model.rd_pos]) begin
            r.action = ACT_STORE;
            r.offset = ring_model.rd_pos - ring_model.wr_end;
         end
      end else if (r.action == ACT_BLOCK) begin
         need = 32'(r.count);
         if (need > BLOCK_LIMIT) need = BLOCK_LIMIT;
         if (need > avail) need = avail;
         run = 0;
         pos = ring_model.rd_pos;
         while (run < need && ring_model.written[pos]) begin
            run++;
            pos = pos + 1'b1;
         end
         if (run == 0) begin
            r.action = ACT_STORE;
            r.offset = ring_model.rd_pos - ring_model.wr_end;
         end else if (run < need) begin
            r.count = PTR_W'(run);
         end
      end
      return r;
   endfunction

   task automatic send_request(ring_request_type raw);
      ring_request_type r;
      int               gap;
      r = keep_to_written(raw);
      req_chan.valid    <= 1'b1;
      req_chan.action   <= r.action;
      req_chan.data_in  <= r.data_in;
      req_chan.has_byte <= r.has_byte;
      req_chan.offset   <= r.offset;
      req_chan.count    <= r.count;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      ring_model.note_action(r);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic run_framed_sequence();
      ring_request_type r;
      int               len;
      int               ops;
      int               i;
      int               roll;
      bit               reverse;
      len     = $urandom_range(1, 12);
      reverse = ($urandom_range(0, 1) != 0);
      for (i = 0; i < len; i++) begin
         r        = random_request();
         r.action = ACT_STORE;
         r.offset = PTR_W'(reverse ? len - 1 - i : i);
         send_request(r);
      end
      r        = random_request();
      r.action = ACT_COMMIT;
      r.count  = PTR_W'(len);
      send_request(r);
      ops = $urandom_range(1, 8);
      for (i = 0; i < ops; i++) begin
         r    = random_request();
         roll = $urandom_range(0, 99);
         if (roll < 30) begin
            r.action = ACT_READ;
         end else if (roll < 45) begin
            r.action = ACT_PEEK;
         end else if (roll < 80) begin
            r.action = ACT_BLOCK;
            if ($urandom_range(0, 4) != 0) r.count = PTR_W'($urandom_range(0, 16));
         end else begin
            r.action = ACT_PUTBACK;
         end
         send_request(r);
      end
   endtask

   // hold the receiver off while stores and commits keep coming
   task automatic flood_while_held();
      ring_request_type r;
      idle_en      = 1'b0;
      hold_request = 1'b1;
      repeat (20) begin
         r        = random_request();
         r.action = ACT_STORE;
         r.offset = '0;
         send_request(r);
         r        = random_request();
         r.action = ACT_COMMIT;
         r.count  = PTR_W'(1);
         send_request(r);
      end
   endtask

   initial begin
      ring_status_type got;
      int              stall;
      stall = 0;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got.data_out    = rsp_chan.data_out;
            got.data_valid  = rsp_chan.data_valid;
            got.op_ok       = rsp_chan.op_ok;
            got.last        = rsp_chan.last;
            got.available   = rsp_chan.available;
            got.free_start  = rsp_chan.free_start;
            got.free_length = rsp_chan.free_length;
            ring_model.check_transfer(got);
         end
         if (stall > 0) begin
            stall--;
         end else if (hold_request) begin
            stall        = HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            stall = pick_gap();
         end
         rsp_chan.ready <= (stall == 0);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int holds_done;
      holds_done = 0;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.action   <= ACT_STORE;
      req_chan.data_in  <= '0;
      req_chan.has_byte <= 1'b0;
      req_chan.offset   <= '0;
      req_chan.count    <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(make_request(ACT_READ, 8'h00, 1'b0, 12'h000, 12'h000));
      send_request(make_request(ACT_BLOCK, 8'h00, 1'b0, 12'h000, 12'hFFF));
      send_request(make_request(ACT_PUTBACK, 8'hFF, 1'b1, 12'h000, 12'h000));
      send_request(make_request(ACT_SPARE, 8'hFF, 1'b1, 12'hFFF, 12'hFFF));
      send_request(make_request(ACT_STORE, 8'h00, 1'b0, 12'h000, 12'h000));
      send_request(make_request(ACT_STORE, 8'hFF, 1'b1, 12'h001, 12'hFFF));
      send_request(make_request(ACT_STORE, 8'hA5, 1'b0, 12'h002, 12'h000));
      send_request(make_request(ACT_STORE, 8'h5A, 1'b0, 12'h003, 12'h000));
      send_request(make_request(ACT_STORE, 8'h3C, 1'b0, 12'hFFF, 12'h000));
      send_request(make_request(ACT_COMMIT, 8'h00, 1'b0, 12'h000, 12'h004));
      send_request(make_request(ACT_PEEK, 8'h00, 1'b0, 12'h000, 12'h000));
      send_request(make_request(ACT_READ, 8'h00, 1'b0, 12'h000, 12'h000));
      send_request(make_request(ACT_PUTBACK, 8'hC3, 1'b1, 12'h000, 12'h000));
      send_request(make_request(ACT_PUTBACK, 8'h99, 1'b1, 12'h000, 12'h000));
      send_request(make_request(ACT_BLOCK, 8'h00, 1'b0, 12'h000, 12'h002));
      send_request(make_request(ACT_BLOCK, 8'h00, 1'b0, 12'h000, 12'hFFF));
      send_request(make_request(ACT_PUTBACK, 8'h00, 1'b0, 12'h000, 12'h000));
      send_request(make_request(ACT_READ, 8'h00, 1'b0, 12'h000, 12'h000));
      send_request(make_request(ACT_CLEAR, 8'h00, 1'b0, 12'h000, 12'h000));
      send_request(make_request(ACT_COMMIT, 8'h00, 1'b0, 12'h000, 12'hFFF));
      send_request(make_request(ACT_BLOCK, 8'h00, 1'b0, 12'h000, 12'h000));
      send_request(make_request(ACT_BLOCK, 8'h00, 1'b0, 12'h000, 12'h004));
      send_request(make_request(ACT_COMMIT, 8'h00, 1'b0, 12'h000, 12'hFFF));
      send_request(make_request(ACT_CLEAR, 8'h00, 1'b0, 12'h000, 12'h000));
      send_request(make_request(ACT_COMMIT, 8'h00, 1'b0, 12'h000, 12'h000));

      while (items_sent < ITEM_TARGET) begin
         idle_en = ($urandom_range(0, 3) != 0);
         if (holds_done < 2 && items_sent >= (holds_done == 0 ? 150 : 320)) begin
            flood_while_held();
            holds_done++;
         end else if ($urandom_range(0, 99) < 65) begin
            run_framed_sequence();
         end else begin
            send_request(random_request());
         end
      end
      req_chan.valid <= 1'b0;

      while (ring_model.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ring_model.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/crbb_pkg.sv
rtl/crbb_req_if.sv
rtl/crbb_rsp_if.sv
rtl/circular_receive_byte_buffer.sv
sim/tb_circular_receive_byte_buffer.sv
